[rtl/core/video_test_pattern_generator_top_assert.svh]
// ----------------------------------------------------------------------------
// video test pattern generator assertion macros
// clocked on clk_i and disabled while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef VIDEO_TEST_PATTERN_GENERATOR_TOP_ASSERT_SVH
`define VIDEO_TEST_PATTERN_GENERATOR_TOP_ASSERT_SVH

// plain property check
`define VTPG_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// same-cycle implication check
`define VTPG_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

[rtl/core/vtpg_pkg.sv]
// ----------------------------------------------------------------------------
// vtpg_pkg
// shared types, constants and color helpers of the test pattern generator
// ----------------------------------------------------------------------------
`default_nettype none

package vtpg_pkg;

  // screen geometry
  localparam int unsigned SCREEN_WIDTH  = 320;
  localparam int unsigned SCREEN_HEIGHT = 480;
  localparam int unsigned STRIP_ROWS    = 12;
  localparam int unsigned BOTTOM_ROW    = SCREEN_HEIGHT - STRIP_ROWS;

  // marker and bar positions cycle through these counts
  localparam logic [4:0] MARK_POSITIONS = 5'd20;
  localparam logic [4:0] BAR_STEPS      = 5'd21;

  // floor(v / 40) for 9-bit v is (v * 205) >> 13
  localparam int unsigned TILE_RECIP = 205;
  localparam int unsigned TILE_SHIFT = 13;

  // rgb565 colors
  localparam logic [15:0] C_BLACK   = 16'h0000;
  localparam logic [15:0] C_WHITE   = 16'hFFFF;
  localparam logic [15:0] C_RED     = 16'hF800;
  localparam logic [15:0] C_GREEN   = 16'h07E0;
  localparam logic [15:0] C_BLUE    = 16'h001F;
  localparam logic [15:0] C_YELLOW  = 16'hFFE0;
  localparam logic [15:0] C_MAGENTA = 16'hF81F;

  // reset values
  localparam logic [31:0] PERIOD_RESET = 32'd500;
  localparam logic [31:0] LAST_RESET   = 32'hFFFF_FFFF;

  typedef enum logic {
    CMD_UPDATE = 1'b0,
    CMD_QUERY  = 1'b1
  } cmd_e;

  typedef enum logic {
    REG_PERIOD_MS = 1'b0,
    REG_ENABLE    = 1'b1
  } cfg_reg_e;

  // phase view that the pattern logic needs
  typedef struct packed {
    logic       odd;
    logic [4:0] mark_pos;
    logic [4:0] bar_len;
  } phase_info_t;

  // vertical bar colors, 64 pixels each
  function automatic logic [15:0] bar_color(input logic [2:0] idx);
    logic [15:0] c;
    case (idx)
      3'd0:    c = C_RED;
      3'd1:    c = C_GREEN;
      3'd2:    c = C_BLUE;
      3'd3:    c = C_YELLOW;
      3'd4:    c = C_MAGENTA;
      default: c = C_BLACK;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

[rtl/core/vtpg_pattern.sv]
// ----------------------------------------------------------------------------
// vtpg_pattern
// pixel color of the current phase at one screen position
// ----------------------------------------------------------------------------
`default_nettype none

module vtpg_pattern (
  input  logic [8:0]           pixel_x_i,
  input  logic [8:0]           pixel_y_i,
  input  vtpg_pkg::phase_info_t phase_i,
  output logic [15:0]          color_o
);
  import vtpg_pkg::*;

  logic [16:0] tile_x_prod;
  logic [16:0] tile_y_prod;
  logic        tile_white;
  logic [4:0]  col16;
  logic        on_screen;
  logic [15:0] base;

  // tile index parity via reciprocal multiply
  assign tile_x_prod = {8'd0, pixel_x_i} * 17'(TILE_RECIP);
  assign tile_y_prod = {8'd0, pixel_y_i} * 17'(TILE_RECIP);
  assign tile_white  = tile_x_prod[TILE_SHIFT] ^ tile_y_prod[TILE_SHIFT];

  // 16-pixel column group for marker and bottom bar
  assign col16     = pixel_x_i[8:4];
  assign on_screen = (pixel_x_i < 9'(SCREEN_WIDTH)) && (pixel_y_i < 9'(SCREEN_HEIGHT));

  // base pattern plus overlays
  always_comb begin
    if (phase_i.odd) begin
      base = tile_white ? C_WHITE : C_BLACK;
    end else begin
      base = bar_color(pixel_x_i[8:6]);
    end
    if (!on_screen) begin
      color_o = C_BLACK;
    end else if (pixel_y_i < 9'(STRIP_ROWS)) begin
      color_o = (col16 == phase_i.mark_pos) ? C_WHITE : C_BLACK;
    end else if ((pixel_y_i >= 9'(BOTTOM_ROW)) && (col16 < phase_i.bar_len)) begin
      color_o = C_GREEN;
    end else begin
      color_o = base;
    end
  end

endmodule

`default_nettype wire

[rtl/core/video_test_pattern_generator_top.sv]
// ----------------------------------------------------------------------------
// video_test_pattern_generator_top
// animated rgb565 test pattern, one pixel query or update poll per word
// ----------------------------------------------------------------------------
// The block returns exactly one result word for each word it takes: the word
// lands in an input register, the phase update or pixel color is worked out
// in one pass and stored in the result register. Throughput is one word per
// cycle with no gaps while out_stall_i is low; the update path (32-bit
// elapsed-time subtract and compare) sets the cycle. A query sees the phase
// left by all earlier words. The user must write configuration through the
// plain write port only while the block is idle; it is not enforced.
`default_nettype none

module video_test_pattern_generator_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        cmd_i,
  input  logic [31:0] now_ms_i,
  input  logic [8:0]  pixel_x_i,
  input  logic [8:0]  pixel_y_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] pixel_color_o,
  output logic        advanced_o,
  output logic [31:0] phase_now_o,
  // configuration
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  import vtpg_pkg::*;

  `include "video_test_pattern_generator_top_assert.svh"

  // configuration registers
  logic [31:0] period_q;
  logic        enable_q;

  // phase state
  logic [31:0] last_q,   last_d;
  logic        updated_q, updated_d;
  logic [31:0] phase_q,  phase_d;
  logic [4:0]  mark_q,   mark_d;
  logic [4:0]  bar_q,    bar_d;

  // input register
  logic        s1_valid_q, s1_valid_d;
  cmd_e        s1_cmd_q;
  logic [31:0] s1_now_q;
  logic [8:0]  s1_x_q;
  logic [8:0]  s1_y_q;

  // result register
  logic        out_valid_q, out_valid_d;
  logic [15:0] color_q;
  logic        adv_q;
  logic [31:0] phase_out_q;

  logic        s2_free;
  logic        s1_fire;
  logic        in_fire;
  logic [31:0] elapsed;
  logic        do_adv;
  logic [15:0] query_color;
  phase_info_t phase_info;

  // handshake
  assign s2_free    = !out_valid_q || !out_stall_i;
  assign s1_fire    = s1_valid_q && s2_free;
  assign in_stall_o = s1_valid_q && !s2_free;
  assign in_fire    = in_valid_i && !in_stall_o;

  always_comb begin
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end else if (s1_fire) begin
      s1_valid_d = 1'b0;
    end else begin
      s1_valid_d = s1_valid_q;
    end
    if (s1_fire) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= PERIOD_RESET;
      enable_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_PERIOD_MS: period_q <= cfg_data_i;
        REG_ENABLE:    enable_q <= cfg_data_i[0];
        default:       ;
      endcase
    end
  end

  // phase advance decision
  assign elapsed = s1_now_q - last_q;
  assign do_adv  = s1_fire && (s1_cmd_q == CMD_UPDATE) && enable_q &&
                   (!updated_q || (elapsed >= period_q));

  always_comb begin
    last_d    = last_q;
    updated_d = updated_q;
    phase_d   = phase_q;
    mark_d    = mark_q;
    bar_d     = bar_q;
    if (do_adv) begin
      last_d    = s1_now_q;
      updated_d = 1'b1;
      phase_d   = phase_q + 32'd1;
      // phase wraps to zero, so do the residues
      if (phase_q == 32'hFFFF_FFFF) begin
        mark_d = 5'd0;
        bar_d  = 5'd0;
      end else begin
        mark_d = (mark_q == MARK_POSITIONS - 5'd1) ? 5'd0 : mark_q + 5'd1;
        bar_d  = (bar_q == BAR_STEPS - 5'd1) ? 5'd0 : bar_q + 5'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q    <= LAST_RESET;
      updated_q <= 1'b0;
      phase_q   <= 32'd0;
      mark_q    <= 5'd0;
      bar_q     <= 5'd0;
    end else begin
      last_q    <= last_d;
      updated_q <= updated_d;
      phase_q   <= phase_d;
      mark_q    <= mark_d;
      bar_q     <= bar_d;
    end
  end

  // pixel color from the current phase
  assign phase_info.odd      = phase_q[0];
  assign phase_info.mark_pos = mark_q;
  assign phase_info.bar_len  = bar_q;

  vtpg_pattern u_pattern (
    .pixel_x_i (s1_x_q),
    .pixel_y_i (s1_y_q),
    .phase_i   (phase_info),
    .color_o   (query_color)
  );

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // input payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_cmd_q <= cmd_e'(cmd_i);
      s1_now_q <= now_ms_i;
      s1_x_q   <= pixel_x_i;
      s1_y_q   <= pixel_y_i;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      color_q     <= (s1_cmd_q == CMD_QUERY) ? query_color : C_BLACK;
      adv_q       <= do_adv;
      phase_out_q <= phase_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pixel_color_o = color_q;
  assign advanced_o    = adv_q;
  assign phase_now_o   = phase_out_q;

  // checks
  `VTPG_ASSERT_IMPLY(a_adv_no_color, out_valid_o && advanced_o, pixel_color_o == C_BLACK, "advance word carries a color")
  `VTPG_ASSERT(a_residue_range, (mark_q < MARK_POSITIONS) && (bar_q < BAR_STEPS), "phase residue out of range")
  `VTPG_ASSERT(a_phase_step, do_adv |=> (phase_q == 32'($past(phase_q) + 32'd1)), "phase did not step by one")
  `VTPG_ASSERT(a_phase_hold, !do_adv |=> $stable(phase_q), "phase moved without an advance")
  `VTPG_ASSERT_IMPLY(a_stall_full, in_stall_o, s1_valid_q && out_valid_q, "stall with a free stage")

endmodule

`default_nettype wire
